/* rtl/lzss_dec_pkg.sv */
// lzss_dec_pkg: window geometry, reset values and flag constants for the LZSS decompressor.
// Used by lzss_decompressor_top; depends on nothing.
package lzss_dec_pkg;

  // History window geometry
  localparam int WINDOW_SIZE = 4096;
  localparam int ADDR_W      = 12;
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LOOKAHEAD   = 18;

  // Default bias added to the coded copy length (plus one)
  localparam int LENGTH_BIAS_DEF = 2;

  // Write position at the start of every stream
  localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WINDOW_SIZE - LOOKAHEAD);

  // Fill count once every entry of the window has been written
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);

  // Reset value of the fill byte (ASCII space)
  localparam logic [7:0] FILL_RESET = 8'h20;

  // Units described by one flag byte
  localparam logic [3:0] FLAG_COUNT = 4'd8;

endpackage

/* rtl/lzss_decompressor_top.sv */
// lzss_decompressor_top: LZSS decoder with a 4096-byte history window in a synchronous RAM.
// Depends on lzss_dec_pkg.
//
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   in_tdata = in_byte, in_tlast = stream_end
// out_     out  out_tvalid/tready  out_tdata = out_byte, out_tlast = run_last
// cfg_     in   cfg_wr_en          cfg_wr_data = fill_byte
//
// A flag byte, the low half of a pair or a literal is handled without a copy. The high half of a pair
// starts a copy: one history RAM read is issued per cycle while the output is not stalled, and its byte is
// emitted and written back once the registered read returns, so the single read port sets the copy rate.
// No clearing pass is needed: entries outside the range written since the last refill are
// tracked by a base position and a fill count and read as the fill byte.
// A stalled output holds the copy; input is taken only while no copy runs and the output
// register is free or being emptied.
module lzss_decompressor_top
  import lzss_dec_pkg::*;
#(
  parameter int LENGTH_BIAS = LENGTH_BIAS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // in_tdata: [7:0] in_byte
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  // out_tdata: [7:0] out_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  // cfg_wr_data: [7:0] fill_byte
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int LEN_W = $clog2(LENGTH_BIAS + 17);
  localparam logic [LEN_W-1:0] LEN_ADD = LEN_W'(LENGTH_BIAS + 1);

  typedef enum logic {S_IDLE, S_COPY} state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        flag_bits_r, flag_bits_nxt;
  logic [3:0]        flags_left_r, flags_left_nxt;
  logic              pair_pend_r, pair_pend_nxt;
  logic [7:0]        pair_low_r, pair_low_nxt;
  logic              end_pend_r, end_pend_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]  rd_left_r, rd_left_nxt;
  logic [LEN_W-1:0]  em_left_r, em_left_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        fwd_r, fwd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic [7:0]        hist_mem [WINDOW_SIZE];
  logic [7:0]        mem_q;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data;

  logic              out_free, in_acc, move, issue;
  logic [7:0]        byte_res;
  logic [CNT_W-1:0]  cnt_inc;
  logic [ADDR_W-1:0] src_off;
  logic [LEN_W-1:0]  pair_len;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Resolve the pending read: forwarded write, stored entry, or fill byte
  assign byte_res = hit_r ? fwd_r : (valid_r ? mem_q : fill_r);
  assign cnt_inc  = (cnt_r == CNT_FULL) ? cnt_r : cnt_r + CNT_W'(1);
  assign src_off  = src_r - base_r;
  assign pair_len = LEN_W'(in_tdata[3:0]) + LEN_ADD;

  // Copy engine handshake
  assign move  = (state_r == S_COPY) && pend_r && out_free;
  assign issue = (state_r == S_COPY) && (rd_left_r != '0) && (!pend_r || move);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    wp_nxt         = wp_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    pair_pend_nxt  = pair_pend_r;
    pair_low_nxt   = pair_low_r;
    end_pend_nxt   = end_pend_r;
    src_nxt        = src_r;
    rd_left_nxt    = rd_left_r;
    em_left_nxt    = em_left_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    valid_nxt      = valid_r;
    fwd_nxt        = fwd_r;
    out_valid_nxt  = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = wp_r;
    wr_data        = byte_res;
    rd_en          = 1'b0;
    rd_addr        = src_r;

    // Refill the window: nothing written before now counts as stored
    if (cfg_wr_en) begin
      fill_nxt = cfg_wr_data;
      base_nxt = wp_r;
      cnt_nxt  = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (flags_left_r == 4'd0) begin
            // Load a new flag byte
            flag_bits_nxt  = in_tdata;
            flags_left_nxt = FLAG_COUNT;
          end else if (pair_pend_r) begin
            // Second half of a pair: start the copy
            src_nxt        = {in_tdata[7:4], pair_low_r};
            rd_left_nxt    = pair_len;
            em_left_nxt    = pair_len;
            end_pend_nxt   = in_tlast;
            pair_pend_nxt  = 1'b0;
            flag_bits_nxt  = flag_bits_r >> 1;
            flags_left_nxt = flags_left_r - 4'd1;
            state_nxt      = S_COPY;
          end else if (flag_bits_r[0]) begin
            // Literal: emit and store
            out_valid_nxt  = 1'b1;
            out_data_nxt   = in_tdata;
            out_last_nxt   = 1'b1;
            wr_en          = 1'b1;
            wr_data        = in_tdata;
            wp_nxt         = wp_r + ADDR_W'(1);
            cnt_nxt        = cnt_inc;
            flag_bits_nxt  = flag_bits_r >> 1;
            flags_left_nxt = flags_left_r - 4'd1;
          end else begin
            // First half of a pair: hold the low position bits
            pair_low_nxt  = in_tdata;
            pair_pend_nxt = 1'b1;
          end

          // Stream end outside a copy: restart at once
          if (in_tlast && !(flags_left_r != 4'd0 && pair_pend_r)) begin
            wp_nxt         = START_POS;
            base_nxt       = START_POS;
            cnt_nxt        = '0;
            flag_bits_nxt  = '0;
            flags_left_nxt = '0;
            pair_pend_nxt  = 1'b0;
            pair_low_nxt   = '0;
          end
        end
      end

      S_COPY: begin
        // Emit the resolved byte and write it back at the write position
        if (move) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = byte_res;
          out_last_nxt  = (em_left_r == LEN_W'(1));
          wr_en         = 1'b1;
          wp_nxt        = wp_r + ADDR_W'(1);
          cnt_nxt       = cnt_inc;
          em_left_nxt   = em_left_r - LEN_W'(1);
          pend_nxt      = 1'b0;
          if (em_left_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
            if (end_pend_r) begin
              wp_nxt         = START_POS;
              base_nxt       = START_POS;
              cnt_nxt        = '0;
              flag_bits_nxt  = '0;
              flags_left_nxt = '0;
              pair_pend_nxt  = 1'b0;
              pair_low_nxt   = '0;
              end_pend_nxt   = 1'b0;
            end
          end
        end
        // Issue the next source read; forward a same-cycle write to that entry
        if (issue) begin
          rd_en       = 1'b1;
          src_nxt     = src_r + ADDR_W'(1);
          rd_left_nxt = rd_left_r - LEN_W'(1);
          pend_nxt    = 1'b1;
          hit_nxt     = move && (src_r == wp_r);
          fwd_nxt     = byte_res;
          valid_nxt   = {1'b0, src_off} < cnt_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= FILL_RESET;
      wp_r         <= START_POS;
      base_r       <= START_POS;
      cnt_r        <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      pair_pend_r  <= 1'b0;
      pair_low_r   <= '0;
      end_pend_r   <= 1'b0;
      rd_left_r    <= '0;
      em_left_r    <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      wp_r         <= wp_nxt;
      base_r       <= base_nxt;
      cnt_r        <= cnt_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      pair_pend_r  <= pair_pend_nxt;
      pair_low_r   <= pair_low_nxt;
      end_pend_r   <= end_pend_nxt;
      rd_left_r    <= rd_left_nxt;
      em_left_r    <= em_left_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    src_r      <= src_nxt;
    hit_r      <= hit_nxt;
    valid_r    <= valid_nxt;
    fwd_r      <= fwd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // History window RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= hist_mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  // Reads issued never run ahead of bytes emitted by more than the one pending read
  a_copy_balance: assert property (@(posedge clk) disable iff (!rst_n)
    em_left_r == rd_left_r + LEN_W'(pend_r))
    else $error("copy read and emit counters out of step");

  // A pending read only exists during a copy
  a_pend_copy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_COPY))
    else $error("pending read outside a copy");

  // The last byte of a copy returns the decoder to idle
  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (move && em_left_r == LEN_W'(1)) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("copy did not finish after its last byte");

  // The fill count never exceeds the window
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("fill count beyond window size");
`endif

endmodule

/* sim/tb_lzss_decompressor_top.sv */
`timescale 1ns / 1ps
// tb_lzss_decompressor_top: self-checking testbench for the LZSS decompressor.
// Depends on lzss_dec_pkg and lzss_decompressor_top; predicts every output beat
// from its own model of the history window and the flag state.
module tb_lzss_decompressor_top;
  import lzss_dec_pkg::*;

  localparam int BIAS          = LENGTH_BIAS_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 280;
  localparam int MAX_REPORTS   = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;
  typedef enum {END_AT_FLAG, END_AT_UNIT, END_IN_PAIR} stream_end_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = 8'h00;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // Decoder model state
  logic [7:0]        hist_win [WINDOW_SIZE];
  logic [ADDR_W-1:0] wr_pos;
  logic [7:0]        flag_bits;
  logic [3:0]        flags_left;
  logic              pair_pending;
  logic [7:0]        pair_low;
  logic [7:0]        fill_value;
  out_beat_t         expected_bytes [$];

  stall_mode_t stall_mode = STALL_RANDOM;
  bit          gaps_on    = 1'b1;
  int          burst_left = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;

  always #1 clk = ~clk;

  lzss_decompressor_top #(
    .LENGTH_BIAS(BIAS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------- model

  function automatic void refill_window();
    for (int i = 0; i < WINDOW_SIZE; i++) hist_win[i] = fill_value;
  endfunction

  function automatic void restart_stream();
    refill_window();
    wr_pos       = START_POS;
    flag_bits    = 8'h00;
    flags_left   = 4'd0;
    pair_pending = 1'b0;
    pair_low     = 8'h00;
  endfunction

  function automatic void emit_byte(input logic [7:0] b, input logic last);
    expected_bytes.push_back('{data: b, last: last});
    hist_win[wr_pos] = b;
    wr_pos++;
  endfunction

  function automatic void consume_flag();
    flag_bits  = flag_bits >> 1;
    flags_left = flags_left - 4'd1;
  endfunction

  // Advance the decoder by one compressed byte and queue the bytes it yields
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] rd;
    int                copy_len;
    if (flags_left == 4'd0) begin
      flag_bits  = b;
      flags_left = FLAG_COUNT;
    end else if (pair_pending) begin
      src      = {b[7:4], pair_low};
      copy_len = int'(b[3:0]) + BIAS + 1;
      // read after each write so overlapping copies repeat themselves
      for (int k = 0; k < copy_len; k++) begin
        rd = src + ADDR_W'(k);
        emit_byte(hist_win[rd], k == copy_len - 1);
      end
      pair_pending = 1'b0;
      consume_flag();
    end else if (flag_bits[0]) begin
      emit_byte(b, 1'b1);
      consume_flag();
    end else begin
      pair_low     = b;
      pair_pending = 1'b1;
    end
    if (eos) restart_stream();
  endfunction

  // ---------------------------------------------------------------- output side

  // Check each accepted beat, then pick the next ready value
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual data=%02h last=%b",
                   $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: out_tdata mismatch, expected %02h, actual %02h",
                     $time, want.data, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: out_tlast mismatch, expected %b, actual %b",
                     $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
    case (stall_mode)
      STALL_NONE: begin
        out_tready <= 1'b1;
      end
      STALL_RANDOM: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 16);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- input side

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid for a random gap at the end of each burst
  task automatic pace();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender($urandom_range(1, 8));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_tdata  <= b;
    in_tlast  <= eos;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eos);
    items_sent++;
    pace();
  endtask

  task automatic send_pair(input logic [ADDR_W-1:0] src, input logic [3:0] len_code,
                           input logic end_high);
    send_byte(src[7:0], 1'b0);
    send_byte({src[11:8], len_code}, end_high);
  endtask

  // Hold input until every expected beat is out, then let the block settle
  task automatic drain();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only call while the block is idle
  task automatic write_fill(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fill_value = v;
    refill_window();
  endtask

  // One stream of random groups, ended on the last flag byte, after a unit of the last group or inside a pair
  task automatic random_stream(input int n_groups);
    logic [7:0]        flags;
    logic [ADDR_W-1:0] src;
    stream_end_t       end_kind;
    int                end_unit;
    bit                is_end;
    end_kind = stream_end_t'($urandom_range(0, 2));
    end_unit = $urandom_range(0, 7);
    for (int g = 0; g < n_groups; g++) begin
      flags = 8'($urandom);
      if (g == n_groups - 1 && end_kind == END_AT_FLAG) begin
        send_byte(flags, 1'b1);
        return;
      end
      send_byte(flags, 1'b0);
      for (int u = 0; u < 8; u++) begin
        is_end = (g == n_groups - 1) && (u == end_unit);
        if (flags[u]) begin
          send_byte(8'($urandom), is_end);
        end else begin
          // mostly copy from just behind the write position
          if ($urandom_range(0, 9) < 7) src = wr_pos - ADDR_W'($urandom_range(1, 40));
          else src = ADDR_W'($urandom);
          if (is_end && end_kind == END_IN_PAIR) send_byte(src[7:0], 1'b1);
          else send_pair(src, 4'($urandom), is_end);
        end
        if (is_end) return;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // All-literal group with extreme values, stream ended on a literal
  task automatic test_literals();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
  endtask

  // Shortest and longest copies, overlap, wrap-around, end inside a pair
  task automatic test_copies();
    send_byte(8'h02, 1'b0);
    send_pair(12'h000, 4'h0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_pair(wr_pos - 12'd1, 4'hF, 1'b0);
    send_pair(12'hFF0, 4'hF, 1'b0);
    send_byte(8'h9B, 1'b1);
  endtask

  // End on a flag byte, then a fill write in the middle of a stream
  task automatic test_stream_ends_and_fill();
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain();
    write_fill(8'h00);
    send_pair(START_POS, 4'h1, 1'b1);
    drain();
    write_fill(8'hFF);
  endtask

  task automatic test_random_traffic();
    int target;
    int n;
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        1:       write_fill(8'h00);
        2:       write_fill(8'hFF);
        default: write_fill(8'($urandom));
      endcase
      case (p)
        0:       begin stall_mode = STALL_NONE;   gaps_on = 1'b0; end
        1:       begin stall_mode = STALL_RANDOM; gaps_on = 1'b1; end
        2:       begin stall_mode = STALL_BURSTY; gaps_on = 1'b1; end
        default: begin stall_mode = STALL_BURSTY; gaps_on = 1'b0; end
      endcase
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // raw bytes, closed by an end mark so later streams stay aligned
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
        end else begin
          random_stream($urandom_range(1, 4));
        end
        if ($urandom_range(0, 7) == 0) drain();
      end
    end
  endtask

  // ---------------------------------------------------------------- run

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    fill_value = FILL_RESET;
    restart_stream();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals();
    test_copies();
    test_stream_ends_and_fill();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
